// ----- rtl/core/tstt_pkg.sv -----
// ----------------------------------------------------------------------------
// tstt_pkg
// Shared types, constants and score helpers for the two-slot
// transposition table.
// ----------------------------------------------------------------------------
package tstt_pkg;

    localparam int unsigned ENTRIES = 16384;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned TAG_W   = 64 - IDX_W;
    localparam int unsigned CFG_W   = 15;

    // Configuration register indexes
    localparam logic CFG_MATE_SCORE  = 1'b0;
    localparam logic CFG_MATE_WINDOW = 1'b1;

    // Operation codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    // Bound kinds
    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_UPPER = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;

    localparam logic [15:0] MATE_SCORE_RST  = 16'd30000;
    localparam logic [7:0]  MATE_WINDOW_RST = 8'd64;

    typedef struct packed {
        logic                    valid;
        logic [TAG_W-1:0]        tag;
        logic [31:0]             move;
        logic signed [15:0]      score;
        logic [7:0]              age;
        logic [7:0]              depth;
        logic [1:0]              kind;
    } slot_t;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic finish;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } status_t;

    // Clamp an 18-bit signed value to the 16-bit signed range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7fff;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/tstt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tstt_ctrl
// Sequencer for the transposition table: clearing pass after reset, then
// accept, memory read, evaluate and retire for each item.
// ----------------------------------------------------------------------------
module tstt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tstt_pkg::status_t status,
    output tstt_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.step1  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.step2  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result retired over a waiting result");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_READ))
        else $error("accepted item did not start a read");

    a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result shown without retire");

endmodule

// ----- rtl/core/tstt_dp.sv -----
// ----------------------------------------------------------------------------
// tstt_dp
// Datapath: configuration registers, input registers, the two slot
// memories, score adjustment, probe evaluation and the result register.
// ----------------------------------------------------------------------------
module tstt_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tstt_pkg::cmd_t             cmd,
    output tstt_pkg::status_t          status,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [tstt_pkg::CFG_W-1:0] cfg_data,
    input  logic                       func,
    input  logic [63:0]                key,
    input  logic [7:0]                 age,
    input  logic [7:0]                 depth,
    input  logic signed [15:0]         score,
    input  logic [1:0]                 bound_kind,
    input  logic [31:0]                best_move,
    input  logic [7:0]                 ply,
    input  logic signed [15:0]         alpha,
    input  logic signed [15:0]         beta,
    output logic                       hit,
    output logic signed [15:0]         value,
    output logic                       move_found,
    output logic [31:0]                found_move
);

    tstt_pkg::slot_t first_mem  [tstt_pkg::ENTRIES];
    tstt_pkg::slot_t second_mem [tstt_pkg::ENTRIES];

    logic [14:0]                   mate_score_reg;
    logic [7:0]                    mate_window_reg;
    logic signed [17:0]            hi_reg;
    logic signed [17:0]            lo_reg;
    logic signed [17:0]            hi_next;
    logic signed [17:0]            ms_s;

    logic [tstt_pkg::IDX_W-1:0]    clr_idx_reg;

    logic                          func_reg;
    logic [tstt_pkg::IDX_W-1:0]    idx_reg;
    logic [tstt_pkg::TAG_W-1:0]    tag_reg;
    logic [7:0]                    age_reg;
    logic [7:0]                    depth_reg;
    logic signed [15:0]            score_reg;
    logic [1:0]                    kind_reg;
    logic [31:0]                   move_reg;
    logic [7:0]                    ply_reg;
    logic signed [15:0]            alpha_reg;
    logic signed [15:0]            beta_reg;

    tstt_pkg::slot_t               rd1_reg;
    tstt_pkg::slot_t               rd2_reg;

    logic signed [15:0]            adj1_reg;
    logic signed [15:0]            adj1_next;
    logic signed [15:0]            adj2_reg;
    logic signed [15:0]            adj2_next;
    logic                          repl_first_reg;
    logic                          match1_reg;
    logic                          match2_reg;
    logic                          deep1_reg;
    logic                          deep2_reg;
    logic signed [15:0]            esc1_reg;
    logic signed [15:0]            esc2_reg;

    logic signed [17:0]            ply_s;
    logic signed [17:0]            s_ext;
    logic signed [17:0]            a_ext;

    logic                          hit1;
    logic                          hit2;
    logic                          we1;
    logic                          we2;
    logic [tstt_pkg::IDX_W-1:0]    waddr;
    tstt_pkg::slot_t               wdata;

    logic                          hit_reg;
    logic signed [15:0]            value_reg;
    logic                          move_found_reg;
    logic [31:0]                   found_move_reg;

    // Move a stored mate score back toward the root
    function automatic logic signed [15:0] esc(
        input logic signed [15:0] s,
        input logic signed [17:0] hi,
        input logic signed [17:0] lo,
        input logic signed [17:0] p
    );
        logic signed [17:0] e;
        logic signed [15:0] r;
        e = {{2{s[15]}}, s};
        if (e >= hi)
            r = tstt_pkg::sat16(e - p);
        else if (e <= lo)
            r = tstt_pkg::sat16(e + p);
        else
            r = s;
        return r;
    endfunction

    function automatic logic kind_ok(
        input logic [1:0]         k,
        input logic signed [15:0] e,
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        logic r;
        unique case (k)
            tstt_pkg::KIND_EXACT: r = 1'b1;
            tstt_pkg::KIND_UPPER: r = (e <= a);
            tstt_pkg::KIND_LOWER: r = (e >= b);
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mate_score_reg  <= tstt_pkg::MATE_SCORE_RST[14:0];
            mate_window_reg <= tstt_pkg::MATE_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tstt_pkg::CFG_MATE_SCORE:  mate_score_reg  <= cfg_data;
                tstt_pkg::CFG_MATE_WINDOW: mate_window_reg <= cfg_data[7:0];
                default:                   mate_score_reg  <= mate_score_reg;
            endcase
        end
    end

    assign ms_s    = $signed({3'b000, mate_score_reg});
    assign hi_next = ms_s - $signed({10'd0, mate_window_reg});

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= -hi_next;
    end

    // ---------------- clearing pass ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign status.clr_last = &clr_idx_reg;

    // ---------------- input registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            idx_reg   <= key[tstt_pkg::IDX_W-1:0];
            tag_reg   <= key[63:tstt_pkg::IDX_W];
            age_reg   <= age;
            depth_reg <= depth;
            score_reg <= score;
            kind_reg  <= bound_kind;
            move_reg  <= best_move;
            ply_reg   <= ply;
            alpha_reg <= alpha;
            beta_reg  <= beta;
        end
    end

    // ---------------- slot memories ----------------
    assign we1   = cmd.clear || (cmd.finish && func_reg == tstt_pkg::FUNC_STORE
                                 && repl_first_reg);
    assign we2   = cmd.clear || (cmd.finish && func_reg == tstt_pkg::FUNC_STORE
                                 && !repl_first_reg);
    assign waddr = cmd.clear ? clr_idx_reg : idx_reg;

    always_comb
    begin
        wdata = '0;
        if (!cmd.clear)
        begin
            wdata.valid = 1'b1;
            wdata.tag   = tag_reg;
            wdata.move  = move_reg;
            wdata.score = adj2_reg;
            wdata.age   = age_reg;
            wdata.depth = depth_reg;
            wdata.kind  = kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            first_mem[waddr] <= wdata;
        end
        if (cmd.load)
        begin
            rd1_reg <= first_mem[key[tstt_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we2)
        begin
            second_mem[waddr] <= wdata;
        end
        if (cmd.load)
        begin
            rd2_reg <= second_mem[key[tstt_pkg::IDX_W-1:0]];
        end
    end

    // ---------------- store score adjustment ----------------
    assign ply_s = $signed({10'd0, ply_reg});
    assign s_ext = {{2{score_reg[15]}}, score_reg};
    assign a_ext = {{2{adj1_reg[15]}}, adj1_reg};

    always_comb
    begin
        if (s_ext >= hi_reg && s_ext <= ms_s)
            adj1_next = tstt_pkg::sat16(s_ext + ply_s);
        else
            adj1_next = score_reg;
    end

    // negative-mate test sees the score after the positive-mate step
    always_comb
    begin
        if (a_ext <= lo_reg && a_ext >= -ms_s)
            adj2_next = tstt_pkg::sat16(a_ext - ply_s);
        else
            adj2_next = adj1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step1)
        begin
            adj1_reg <= adj1_next;
        end
        if (cmd.step2)
        begin
            adj2_reg       <= adj2_next;
            repl_first_reg <= (rd1_reg.depth < depth_reg) || (rd1_reg.age < age_reg);
            match1_reg     <= rd1_reg.valid && (rd1_reg.tag == tag_reg);
            match2_reg     <= rd2_reg.valid && (rd2_reg.tag == tag_reg);
            deep1_reg      <= (rd1_reg.depth >= depth_reg);
            deep2_reg      <= (rd2_reg.depth >= depth_reg);
            esc1_reg       <= esc(rd1_reg.score, hi_reg, lo_reg, ply_s);
            esc2_reg       <= esc(rd2_reg.score, hi_reg, lo_reg, ply_s);
        end
    end

    // ---------------- probe result ----------------
    assign hit1 = match1_reg && deep1_reg
                  && kind_ok(rd1_reg.kind, esc1_reg, alpha_reg, beta_reg);
    assign hit2 = match2_reg && deep2_reg
                  && kind_ok(rd2_reg.kind, esc2_reg, alpha_reg, beta_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (func_reg == tstt_pkg::FUNC_STORE)
            begin
                hit_reg        <= 1'b0;
                value_reg      <= '0;
                move_found_reg <= 1'b0;
                found_move_reg <= '0;
            end
            else if (hit1)
            begin
                // first slot hit ends the probe
                hit_reg        <= 1'b1;
                value_reg      <= esc1_reg;
                move_found_reg <= 1'b1;
                found_move_reg <= rd1_reg.move;
            end
            else
            begin
                hit_reg        <= hit2;
                value_reg      <= hit2 ? esc2_reg : 16'sd0;
                move_found_reg <= match1_reg || match2_reg;
                found_move_reg <= match2_reg ? rd2_reg.move
                                : (match1_reg ? rd1_reg.move : 32'd0);
            end
        end
    end

    assign hit        = hit_reg;
    assign value      = value_reg;
    assign move_found = move_found_reg;
    assign found_move = found_move_reg;

endmodule

// ----- rtl/core/two_slot_transposition_table_unit.sv -----
// ----------------------------------------------------------------------------
// two_slot_transposition_table_unit
// Two-way transposition table: store and probe items against two slot
// memories indexed by the low bits of the position key.
// ----------------------------------------------------------------------------
// Each item passes accept, slot memory read, evaluate and retire in turn, and
// the next item is taken only after the last one retires. These steps are
// set by the sequencer around the two synchronous slot memories, whose read
// data is registered before the key compare and score adjustment. After
// reset both memories are cleared one row a cycle, 16384 rows in all, with
// in_ready low; configuration writes are taken throughout. A finished result
// sits in an output register, so the next item is accepted while it waits;
// an item retires only once that register is free.
module two_slot_transposition_table_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [tstt_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [63:0]                key,
    input  logic [7:0]                 age,
    input  logic [7:0]                 depth,
    input  logic signed [15:0]         score,
    input  logic [1:0]                 bound_kind,
    input  logic [31:0]                best_move,
    input  logic [7:0]                 ply,
    input  logic signed [15:0]         alpha,
    input  logic signed [15:0]         beta,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic signed [15:0]         value,
    output logic                       move_found,
    output logic [31:0]                found_move
);

    tstt_pkg::cmd_t    cmd;
    tstt_pkg::status_t status;

    tstt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tstt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .func       (func),
        .key        (key),
        .age        (age),
        .depth      (depth),
        .score      (score),
        .bound_kind (bound_kind),
        .best_move  (best_move),
        .ply        (ply),
        .alpha      (alpha),
        .beta       (beta),
        .hit        (hit),
        .value      (value),
        .move_found (move_found),
        .found_move (found_move)
    );

endmodule
